// File: hw/rtl/bbn_pkg.sv
package bbn_pkg;

   localparam int COORD_W   = 24;
   localparam int SCALE_W   = 24;
   localparam int OUT_W     = 32;
   localparam int OUT_FRAC  = 16;
   localparam int CSR_IDX_W = 2;

   // divisor magnitude covers both a span and the fixed scale
   localparam int DIV_W  = (COORD_W > SCALE_W) ? COORD_W : SCALE_W;
   localparam int DIVS_W = DIV_W + 1;
   localparam int OFF_W  = COORD_W + 1;
   localparam int NUM_W  = COORD_W + OUT_FRAC;
   localparam int QX_W   = (NUM_W > OUT_W) ? NUM_W : OUT_W + 1;
   localparam int CNT_W  = $clog2(NUM_W + 1);

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [OFF_W-1:0]   off_type;
   typedef logic signed [DIVS_W-1:0]  divs_type;
   typedef logic [DIV_W-1:0]          div_type;
   typedef logic [NUM_W-1:0]          num_type;
   typedef logic [QX_W-1:0]           qx_type;
   typedef logic [CNT_W-1:0]          cnt_type;
   typedef logic [OUT_W-1:0]          norm_type;
   typedef logic [SCALE_W-1:0]        scale_type;
   typedef logic [CSR_IDX_W-1:0]      csr_idx_type;
   typedef logic [1:0]                func_type;
   typedef logic [1:0]                axis_type;

   localparam func_type FUNC_CLEAR = 2'd0;
   localparam func_type FUNC_ADD   = 2'd1;
   localparam func_type FUNC_NORM  = 2'd2;

   localparam csr_idx_type REG_SCALE_MODE  = 2'd0;
   localparam csr_idx_type REG_FIXED_SCALE = 2'd1;

   localparam scale_type SCALE_ONE = 24'd256;
   localparam axis_type  LAST_AXIS = 2'd2;

   localparam coord_type COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_SCALE,
      ST_START,
      ST_WAIT,
      ST_FINISH
   } state_type;

endpackage

// File: hw/rtl/bounding_box_point_normalizer_top.sv
// Clear and add items are taken while idle; the block stays ready for the next item.
// A normalize item finishes sooner when an axis needs no division: one shared
// radix-2 divider yields one quotient bit per cycle, three quotients in turn.
// Synchronous active-high reset empties the box, sets scale_mode 0 and
// fixed_scale to SCALE_ONE (256), and drops any pending result.
module bounding_box_point_normalizer_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bbn_pkg::func_type    req_func,
   input  bbn_pkg::coord_type   req_coord_x,
   input  bbn_pkg::coord_type   req_coord_y,
   input  bbn_pkg::coord_type   req_coord_z,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output bbn_pkg::norm_type    rsp_norm_x,
   output bbn_pkg::norm_type    rsp_norm_y,
   output bbn_pkg::norm_type    rsp_norm_z,
   output logic                 rsp_divide_fault,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  bbn_pkg::csr_idx_type csr_index,
   input  bbn_pkg::scale_type   csr_data
);
   import bbn_pkg::*;

   state_type state_ff, state_in;
   logic      mode_ff;
   scale_type fixed_scale_ff;

   coord_type coord_ff [3];
   coord_type coord_in [3];
   off_type   off_ff   [3];
   off_type   off_in   [3];
   off_type   span_ff  [3];
   off_type   span_in  [3];
   divs_type  div_ff   [3];
   divs_type  div_in   [3];
   norm_type  res_ff   [3];
   norm_type  res_in   [3];
   logic      fault_ff, fault_in;
   axis_type  axis_ff, axis_in;

   logic      rsp_valid_ff, rsp_valid_in;
   norm_type  out_ff [3];
   norm_type  out_in [3];
   logic      out_fault_ff, out_fault_in;

   coord_type req_point [3];
   coord_type box_min   [3];
   coord_type box_max   [3];
   logic      req_take;
   logic      box_clear, box_add;

   logic      div_start;
   logic      div_done;
   num_type   div_quotient;
   num_type   div_dividend;
   qx_type    quo_wide;
   norm_type  quo_sat;
   off_type   span_big;

   assign req_point[0] = req_coord_x;
   assign req_point[1] = req_coord_y;
   assign req_point[2] = req_coord_z;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid & req_ready;
   assign box_clear = req_take & (req_func == FUNC_CLEAR);
   assign box_add   = req_take & (req_func == FUNC_ADD);

   bbn_box u_box (
      .clock     (clock),
      .reset     (reset),
      .clear_i   (box_clear),
      .add_i     (box_add),
      .point_i   (req_point),
      .box_min_o (box_min),
      .box_max_o (box_max)
   );

   assign div_dividend = {off_ff[axis_ff][COORD_W-1:0], {OUT_FRAC{1'b0}}};

   bbn_divider u_divider (
      .clock      (clock),
      .reset      (reset),
      .start_i    (div_start),
      .dividend_i (div_dividend),
      .divisor_i  (div_ff[axis_ff][DIV_W-1:0]),
      .done_o     (div_done),
      .quotient_o (div_quotient)
   );

   // saturate the quotient to Q16.16
   assign quo_wide = QX_W'(div_quotient);
   assign quo_sat  = (|quo_wide[QX_W-1:OUT_W]) ? '1 : quo_wide[OUT_W-1:0];

   always_comb begin
      span_big = span_ff[0];
      if (span_ff[1] > span_big) span_big = span_ff[1];
      if (span_ff[2] > span_big) span_big = span_ff[2];
   end

   always_comb begin
      state_in     = state_ff;
      coord_in     = coord_ff;
      off_in       = off_ff;
      span_in      = span_ff;
      div_in       = div_ff;
      res_in       = res_ff;
      fault_in     = fault_ff;
      axis_in      = axis_ff;
      out_in       = out_ff;
      out_fault_in = out_fault_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      div_start    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_func == FUNC_NORM)) begin
               coord_in = req_point;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            for (int i = 0; i < 3; i++) begin
               off_in[i]  = OFF_W'(coord_ff[i]) - OFF_W'(box_min[i]);
               span_in[i] = OFF_W'(box_max[i]) - OFF_W'(box_min[i]);
            end
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            for (int i = 0; i < 3; i++) begin
               if (!mode_ff) begin
                  div_in[i] = DIVS_W'(span_ff[i]);
               end else if (fixed_scale_ff == SCALE_ONE) begin
                  div_in[i] = DIVS_W'(span_big);
               end else begin
                  div_in[i] = DIVS_W'({1'b0, fixed_scale_ff});
               end
            end
            fault_in = 1'b0;
            axis_in  = '0;
            state_in = ST_START;
         end
         ST_START: begin
            if (div_ff[axis_ff][DIVS_W-1] || (div_ff[axis_ff] == '0)) begin
               res_in[axis_ff] = '0;
               fault_in        = 1'b1;
               state_in        = (axis_ff == LAST_AXIS) ? ST_FINISH : ST_START;
               axis_in         = axis_ff + 1'b1;
            end else if (off_ff[axis_ff][OFF_W-1] || (off_ff[axis_ff] == '0)) begin
               // point at or below the box minimum: clamp to zero
               res_in[axis_ff] = '0;
               state_in        = (axis_ff == LAST_AXIS) ? ST_FINISH : ST_START;
               axis_in         = axis_ff + 1'b1;
            end else begin
               div_start = 1'b1;
               state_in  = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (div_done) begin
               res_in[axis_ff] = quo_sat;
               state_in        = (axis_ff == LAST_AXIS) ? ST_FINISH : ST_START;
               axis_in         = axis_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               out_in       = res_ff;
               out_fault_in = fault_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         mode_ff        <= 1'b0;
         fixed_scale_ff <= SCALE_ONE;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_SCALE_MODE) mode_ff <= csr_data[0];
            if (csr_index == REG_FIXED_SCALE) fixed_scale_ff <= csr_data;
         end
      end
      coord_ff     <= coord_in;
      off_ff       <= off_in;
      span_ff      <= span_in;
      div_ff       <= div_in;
      res_ff       <= res_in;
      fault_ff     <= fault_in;
      axis_ff      <= axis_in;
      out_ff       <= out_in;
      out_fault_ff <= out_fault_in;
   end

   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_norm_x       = out_ff[0];
   assign rsp_norm_y       = out_ff[1];
   assign rsp_norm_z       = out_ff[2];
   assign rsp_divide_fault = out_fault_ff;

endmodule

// File: hw/rtl/bbn_box.sv
module bbn_box (
   input  logic               clock,
   input  logic               reset,
   input  logic               clear_i,
   input  logic               add_i,
   input  bbn_pkg::coord_type point_i   [3],
   output bbn_pkg::coord_type box_min_o [3],
   output bbn_pkg::coord_type box_max_o [3]
);
   import bbn_pkg::*;

   coord_type min_ff [3];
   coord_type max_ff [3];
   coord_type min_in [3];
   coord_type max_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         min_in[i] = min_ff[i];
         max_in[i] = max_ff[i];
         if (clear_i) begin
            min_in[i] = COORD_MAX;
            max_in[i] = COORD_MIN;
         end else if (add_i) begin
            if (point_i[i] < min_ff[i]) min_in[i] = point_i[i];
            if (point_i[i] > max_ff[i]) max_in[i] = point_i[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (reset) begin
            min_ff[i] <= COORD_MAX;
            max_ff[i] <= COORD_MIN;
         end else begin
            min_ff[i] <= min_in[i];
            max_ff[i] <= max_in[i];
         end
      end
   end

   assign box_min_o = min_ff;
   assign box_max_o = max_ff;

endmodule

// File: hw/rtl/bbn_divider.sv
module bbn_divider (
   input  logic             clock,
   input  logic             reset,
   input  logic             start_i,
   input  bbn_pkg::num_type dividend_i,
   input  bbn_pkg::div_type divisor_i,
   output logic             done_o,
   output bbn_pkg::num_type quotient_o
);
   import bbn_pkg::*;

   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   cnt_type        cnt_ff, cnt_in;
   div_type        rem_ff, rem_in;
   div_type        dsr_ff, dsr_in;
   num_type        quo_ff, quo_in;
   logic [DIV_W:0] trial;
   logic [DIV_W:0] diff;
   logic           fits;

   // one restoring step: shift in the next dividend bit, subtract when it fits
   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      if (start_i) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         rem_in  = '0;
         dsr_in  = divisor_i;
         quo_in  = dividend_i;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == cnt_type'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign done_o     = done_ff;
   assign quotient_o = quo_ff;

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import bbn_pkg::*;

   localparam func_type    FUNC_NONE    = 2'd3;
   localparam csr_idx_type REG_SPARE_2  = 2'd2;
   localparam csr_idx_type REG_SPARE_3  = 2'd3;
   localparam int          SETTLE_CYCLES = 150;
   localparam int          HOLD_CYCLES   = 900;
   localparam int          STALL_LIMIT   = 8000;
   localparam int          FULL_SPREAD   = -1;
   localparam int          PHASE_ITEMS   = 66;

   typedef struct {
      func_type  func;
      coord_type x;
      coord_type y;
      coord_type z;
   } point_item_type;

   typedef struct {
      norm_type n[3];
      logic     fault;
   } norm_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   func_type    req_func = FUNC_CLEAR;
   coord_type   req_coord_x = '0;
   coord_type   req_coord_y = '0;
   coord_type   req_coord_z = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   norm_type    rsp_norm_x;
   norm_type    rsp_norm_y;
   norm_type    rsp_norm_z;
   logic        rsp_divide_fault;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   csr_idx_type csr_index = REG_SCALE_MODE;
   scale_type   csr_data = '0;

   point_item_type  point_q[$];
   norm_result_type norm_due[$];

   // mirror of the block's box and registers
   longint    box_lo[3];
   longint    box_hi[3];
   logic      mode_m = 1'b0;
   scale_type scale_m = SCALE_ONE;

   int   pushed_cnt = 0;
   int   accepted_cnt = 0;
   int   norm_cnt = 0;
   int   checked_cnt = 0;
   int   csr_cnt = 0;
   int   err_cnt = 0;
   int   quiet_cycles = 0;
   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   logic csr_fire = 1'b0;

   // traffic shaping, set per phase
   logic idle_on = 1'b0;
   int   stall_pct = 0;
   logic hold_req = 1'b0;
   logic hold_done = 1'b0;
   int   hold_left = 0;
   int   run_left = 0;
   int   burst_left = 0;
   int   gap_left = 0;

   bounding_box_point_normalizer_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .req_coord_z      (req_coord_z),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_norm_x       (rsp_norm_x),
      .rsp_norm_y       (rsp_norm_y),
      .rsp_norm_z       (rsp_norm_z),
      .rsp_divide_fault (rsp_divide_fault),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH at %0t: %s got 0x%0h, want 0x%0h", $time, what, got, want);
      err_cnt++;
   endtask

   function automatic coord_type rand_raw();
      return coord_type'($urandom);
   endfunction

   function automatic scale_type rand_data();
      return scale_type'($urandom);
   endfunction

   function automatic void clear_bbox();
      for (int a = 0; a < 3; a++) begin
         box_lo[a] = longint'(COORD_MAX);
         box_hi[a] = longint'(COORD_MIN);
      end
   endfunction

   // advance the box mirror by one accepted item and queue the normalize result
   function automatic void step_bbox(input point_item_type it);
      longint          pt[3];
      longint          span[3];
      longint          off;
      longint          widest;
      logic [63:0]     quo;
      norm_result_type res;
      pt[0] = longint'(it.x);
      pt[1] = longint'(it.y);
      pt[2] = longint'(it.z);
      case (it.func)
         FUNC_CLEAR: clear_bbox();
         FUNC_ADD: begin
            for (int a = 0; a < 3; a++) begin
               if (pt[a] < box_lo[a]) box_lo[a] = pt[a];
               if (pt[a] > box_hi[a]) box_hi[a] = pt[a];
            end
         end
         FUNC_NORM: begin
            for (int a = 0; a < 3; a++) span[a] = box_hi[a] - box_lo[a];
            if (mode_m) begin
               if (scale_m == SCALE_ONE) begin
                  widest = span[0];
                  if (span[1] > widest) widest = span[1];
                  if (span[2] > widest) widest = span[2];
               end else begin
                  widest = longint'(scale_m);
               end
               for (int a = 0; a < 3; a++) span[a] = widest;
            end
            res.fault = 1'b0;
            for (int a = 0; a < 3; a++) begin
               off = pt[a] - box_lo[a];
               if (span[a] <= 0) begin
                  res.n[a] = '0;
                  res.fault = 1'b1;
               end else if (off <= 0) begin
                  res.n[a] = '0;
               end else begin
                  quo = (off << OUT_FRAC) / span[a];
                  res.n[a] = (quo > 64'hFFFF_FFFF) ? '1 : quo[OUT_W-1:0];
               end
            end
            norm_due.push_back(res);
            norm_cnt++;
         end
         default: ;
      endcase
   endfunction

   function automatic coord_type rand_coord(input longint base, input int spread);
      coord_type c;
      if (spread == FULL_SPREAD) begin
         c = rand_raw();
      end else begin
         c = coord_type'(base + longint'($urandom_range(0, spread + spread / 2))
                         - spread / 4);
      end
      return c;
   endfunction

   task automatic push_point(input func_type f, input coord_type x, input coord_type y,
                             input coord_type z);
      point_item_type it;
      it.func = f;
      it.x = x;
      it.y = y;
      it.z = z;
      point_q.push_back(it);
      pushed_cnt++;
   endtask

   task automatic wait_idle();
      while (accepted_cnt != pushed_cnt || norm_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input csr_idx_type idx, input scale_type data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_SCALE_MODE:  mode_m = data[0];
         REG_FIXED_SCALE: scale_m = data;
         default: ;
      endcase
      csr_cnt++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // driver: bursts of items with random gaps
   always @(negedge clock) begin : driver
      point_item_type cur;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (gap_left > 0 || point_q.size() == 0) begin
            if (gap_left > 0) gap_left--;
            req_valid <= 1'b0;
         end else begin
            cur = point_q.pop_front();
            req_valid <= 1'b1;
            req_func <= cur.func;
            req_coord_x <= cur.x;
            req_coord_y <= cur.y;
            req_coord_z <= cur.z;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 15);
               gap_left = (!idle_on || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
            end
         end
      end
   end

   // receiver: short random stall runs, plus one long hold-off on request
   always @(negedge clock) begin : receiver
      if (hold_req && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (run_left > 0) begin
         run_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         run_left = $urandom_range(0, 6);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : monitor
      norm_result_type due;
      point_item_type  seen;
      req_fire = req_valid && req_ready && !reset;
      rsp_fire = rsp_valid && rsp_ready && !reset;
      csr_fire = csr_valid && csr_ready && !reset;
      if (rsp_fire) begin
         if (norm_due.size() == 0) begin
            report_mismatch("result with nothing due, norm_x", longint'(rsp_norm_x), 64'd0);
         end else begin
            due = norm_due.pop_front();
            checked_cnt++;
            if (rsp_norm_x !== due.n[0])
               report_mismatch("norm_x", longint'(rsp_norm_x), longint'(due.n[0]));
            if (rsp_norm_y !== due.n[1])
               report_mismatch("norm_y", longint'(rsp_norm_y), longint'(due.n[1]));
            if (rsp_norm_z !== due.n[2])
               report_mismatch("norm_z", longint'(rsp_norm_z), longint'(due.n[2]));
            if (rsp_divide_fault !== due.fault)
               report_mismatch("divide_fault", longint'(rsp_divide_fault),
                               longint'(due.fault));
         end
      end
      if (req_fire) begin
         seen.func = req_func;
         seen.x = req_coord_x;
         seen.y = req_coord_y;
         seen.z = req_coord_z;
         step_bbox(seen);
         accepted_cnt++;
      end
      // count only stalled cycles while work is outstanding
      if (req_fire || rsp_fire || csr_fire || reset ||
          (accepted_cnt == pushed_cnt && norm_due.size() == 0 && !csr_valid)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles, %0d results outstanding",
                  STALL_LIMIT, norm_due.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      int        phase_items;
      int        nadd;
      int        nnorm;
      int        spread;
      logic      m;
      scale_type s;
      coord_type bx;
      coord_type by;
      coord_type bz;
      int        pct_tab[8];

      pct_tab = '{0, 30, 60, 15, 45, 80, 10, 35};
      clear_bbox();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      idle_on = 1'b1;
      stall_pct = 25;

      // empty box, ignored code, extreme corners, clamped and saturated offsets
      push_point(FUNC_NORM, rand_raw(), COORD_MIN, COORD_MAX);
      push_point(FUNC_NONE, COORD_MAX, COORD_MIN, rand_raw());
      push_point(FUNC_ADD, COORD_MAX, COORD_MIN, 24'sd0);
      push_point(FUNC_ADD, COORD_MIN, COORD_MAX, 24'sd256);
      push_point(FUNC_NORM, COORD_MAX, COORD_MIN, 24'sd128);
      push_point(FUNC_NORM, COORD_MIN, COORD_MAX, -24'sd256);
      push_point(FUNC_CLEAR, rand_raw(), rand_raw(), rand_raw());
      push_point(FUNC_ADD, 24'sd0, 24'sd0, 24'sd0);
      push_point(FUNC_ADD, 24'sd1, 24'sd2, 24'sd3);
      push_point(FUNC_NORM, COORD_MAX, COORD_MAX, COORD_MAX);
      wait_idle();

      // largest span rule
      csr_write(REG_SCALE_MODE, (rand_data() & 24'hFF_FFFE) | 24'd1);
      push_point(FUNC_NORM, 24'sd2, 24'sd1, COORD_MIN);
      wait_idle();

      csr_write(REG_FIXED_SCALE, 24'd0);
      push_point(FUNC_NORM, 24'sd3, 24'sd3, 24'sd3);
      wait_idle();

      // spare indexes must not disturb either register
      csr_write(REG_FIXED_SCALE, 24'hFF_FFFF);
      push_point(FUNC_NORM, COORD_MAX, COORD_MAX, COORD_MAX);
      wait_idle();
      csr_write(REG_SPARE_2, rand_data());
      csr_write(REG_SPARE_3, rand_data());
      push_point(FUNC_NORM, 24'sd3, 24'sd2, 24'sd1);
      wait_idle();

      csr_write(REG_FIXED_SCALE, 24'd1);
      push_point(FUNC_NORM, 24'sd2, 24'sd2, 24'sd2);
      push_point(FUNC_NORM, COORD_MAX, COORD_MAX, COORD_MAX);
      wait_idle();

      // single point box: every span is zero
      csr_write(REG_SCALE_MODE, rand_data() & 24'hFF_FFFE);
      push_point(FUNC_CLEAR, 24'sd0, 24'sd0, 24'sd0);
      push_point(FUNC_ADD, -24'sd5, -24'sd5, -24'sd5);
      push_point(FUNC_NORM, -24'sd5, 24'sd7, COORD_MIN);
      wait_idle();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin m = 1'b0; s = SCALE_ONE; end
            1: begin m = 1'b1; s = SCALE_ONE; end
            2: begin m = 1'b1; s = scale_type'($urandom_range(1, 4096)); end
            3: begin m = 1'b0; s = rand_data(); end
            4: begin m = 1'b1; s = 24'd1; end
            5: begin m = 1'b1; s = 24'hFF_FFFF; end
            6: begin m = 1'b1; s = 24'd0; end
            default: begin
               m = 1'($urandom_range(0, 1));
               s = scale_type'($urandom_range(1, 1024) * 256);
            end
         endcase
         csr_write(REG_FIXED_SCALE, s);
         csr_write(REG_SCALE_MODE, (rand_data() & 24'hFF_FFFE) | scale_type'(m));
         idle_on = (ph != 0);
         stall_pct = pct_tab[ph];
         // long hold-off so the block backs up into its input
         if (ph == 3) hold_req = 1'b1;

         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            case ($urandom_range(0, 9))
               7: push_point(FUNC_NONE, rand_raw(), rand_raw(), rand_raw());
               8: begin
                  push_point(FUNC_NORM, rand_raw(), rand_raw(), rand_raw());
                  phase_items++;
               end
               9: begin
                  push_point(FUNC_ADD, rand_raw(), rand_raw(), rand_raw());
                  phase_items++;
               end
               default: begin
                  case ($urandom_range(0, 4))
                     0: spread = 0;
                     1: spread = 255;
                     2: spread = 65535;
                     3: spread = 4194303;
                     default: spread = FULL_SPREAD;
                  endcase
                  bx = rand_raw();
                  by = rand_raw();
                  bz = rand_raw();
                  nadd = $urandom_range(0, 6);
                  nnorm = $urandom_range(1, 4);
                  push_point(FUNC_CLEAR, rand_raw(), rand_raw(), rand_raw());
                  repeat (nadd) push_point(FUNC_ADD, rand_coord(bx, spread),
                                           rand_coord(by, spread), rand_coord(bz, spread));
                  repeat (nnorm) push_point(FUNC_NORM, rand_coord(bx, spread),
                                            rand_coord(by, spread), rand_coord(bz, spread));
                  phase_items += 1 + nadd + nnorm;
               end
            endcase
         end
         wait_idle();
      end

      if (norm_due.size() != 0)
         report_mismatch("normalize results never returned", longint'(norm_due.size()),
                         64'd0);
      $display("Run covered %0d items, %0d of %0d normalize results checked, %0d writes.",
               accepted_cnt, checked_cnt, norm_cnt, csr_cnt);
      $display("Settings spanned per-axis, largest-span and fixed scales from 0 to full range.");
      if (err_cnt == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
